// ----- src/bmg_pkg.sv -----
// Shared types and constants for the Box-Muller Gaussian generator.
package bmg_pkg;

    localparam int FRAC_BITS    = 30;
    localparam int LOG_STEPS    = 30;
    localparam int SERIES_CELLS = 6;
    localparam int SAMPLE_INT   = 4;

    typedef logic [30:0]        t_q30;
    typedef logic signed [31:0] t_trig;

    localparam t_q30 Q30_ONE     = 31'h4000_0000;
    localparam t_q30 LN2_Q30     = 31'd744261118;
    localparam t_q30 HALF_PI_Q30 = 31'd1686629713;

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } t_quad;

    typedef struct packed {
        t_quad quad;
        logic  swap;
    } t_octant;

    function automatic int cos_div(input int i);
        return (2 * i + 1) * (2 * i + 2);
    endfunction

    function automatic int sin_div(input int i);
        return (2 * i + 2) * (2 * i + 3);
    endfunction

endpackage

// ----- src/box_muller_gaussian_generator.sv -----
// New input items enter while earlier ones are in flight; the two samples per item leave
// one per cycle through the output buffer, and the pipeline stalls while its tail is blocked.
// The depth is set by the 30 logarithm cells and the one-bit-per-cell square-root chain.
// Reset is synchronous, active low, and clears valid bits and the output buffer only.
module box_muller_gaussian_generator #(
    parameter int UNIFORM_BITS = 32,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // radius_uniform, angle_uniform
    input  logic [((2*UNIFORM_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  logic                                     i_m_axis_tready,
    // normal_sample
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]         o_m_axis_tdata,
    output logic                                     o_m_axis_tlast
);
    import bmg_pkg::*;

    localparam int OUT_W     = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int MW        = UNIFORM_BITS + 1;
    localparam int EW        = $clog2(UNIFORM_BITS + 1);
    localparam int NW        = EW + FRAC_BITS;
    localparam int SW        = EW + 31;
    localparam int RW0       = SW + 20;
    localparam int RW        = RW0 + (RW0 % 2);
    localparam int QW        = RW / 2;
    localparam int RAD_DEPTH = 5 + LOG_STEPS + QW;
    localparam int ANG_DEPTH = 5 + 3 * SERIES_CELLS;
    localparam int PAD       = RAD_DEPTH - ANG_DEPTH;
    localparam int DEPTH     = RAD_DEPTH + 2;
    localparam int SH        = 55 - (SAMPLE_BITS - SAMPLE_INT);
    localparam int PW        = QW + 31;
    localparam logic [NW-1:0] N_TOP   = NW'(UNIFORM_BITS) << FRAC_BITS;
    localparam logic [PW:0]   ROUND   = (PW+1)'(1) << (SH - 1);
    localparam logic [PW:0]   NEG_LIM = (PW+1)'(1) << (SAMPLE_BITS - 1);
    localparam logic [PW:0]   POS_LIM = NEG_LIM - (PW+1)'(1);

    logic w_adv, w_acc, w_can_load;
    logic [DEPTH-1:0] r_vld;

    logic [UNIFORM_BITS-1:0] w_u1, w_u2, w_u2_dly;

    assign w_u1 = i_s_axis_tdata[UNIFORM_BITS-1:0];
    assign w_u2 = i_s_axis_tdata[2*UNIFORM_BITS-1:UNIFORM_BITS];

    assign w_can_load      = !o_m_axis_tvalid || (o_m_axis_tlast && i_m_axis_tready);
    assign w_adv           = !r_vld[DEPTH-1] || w_can_load;
    assign w_acc           = i_s_axis_tvalid && w_adv;
    assign o_s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[DEPTH-2:0], w_acc};
        end
    end

    // ---------------- Radius path: normalize, logarithm, scale, root ----------------
    logic [MW-1:0]    w_m;
    logic [EW-1:0]    w_e;
    logic [MW-1:0]    r_r0_m;
    logic [EW-1:0]    r_r0_e;
    logic [MW+29:0]   w_ext;
    t_q30             r_r1_f;
    logic [EW-1:0]    r_r1_e;

    assign w_m = MW'(w_u1) + MW'(1);

    always_comb begin
        w_e = '0;
        for (int i = 0; i < MW; i++) begin
            if (w_m[i]) begin
                w_e = EW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_r0_m <= w_m;
            r_r0_e <= w_e;
        end
    end

    assign w_ext = {r_r0_m, 30'b0} >> r_r0_e;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_r1_f <= w_ext[30:0];
            r_r1_e <= r_r0_e;
        end
    end

    t_q30        w_lf    [LOG_STEPS+1];
    logic [29:0] w_lfrac [LOG_STEPS+1];
    logic [EW-1:0] w_le  [LOG_STEPS+1];

    assign w_lf[0]    = r_r1_f;
    assign w_lfrac[0] = '0;
    assign w_le[0]    = r_r1_e;

    for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
        bmg_log_cell #(.EW(EW)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_f    (w_lf[g]),
            .i_frac (w_lfrac[g]),
            .i_e    (w_le[g]),
            .o_f    (w_lf[g+1]),
            .o_frac (w_lfrac[g+1]),
            .o_e    (w_le[g+1])
        );
    end

    logic [NW-1:0]   r_s1_n;
    logic [EW+31:0]  r_s2_pi;
    logic [31:0]     r_s2_pf;
    logic [61:0]     w_pf;
    logic [RW-1:0]   r_s3_rad;
    logic [SW-1:0]   w_s;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_n <= N_TOP - {w_le[LOG_STEPS], w_lfrac[LOG_STEPS]};
        end
    end

    assign w_pf = 62'(r_s1_n[29:0]) * 62'({LN2_Q30, 1'b0});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_pi <= (EW+32)'(r_s1_n[NW-1:30]) * (EW+32)'({LN2_Q30, 1'b0});
            r_s2_pf <= w_pf[61:30];
        end
    end

    assign w_s = SW'(r_s2_pi) + SW'(r_s2_pf);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_rad <= RW'({w_s, 20'b0});
        end
    end

    logic [RW-1:0] w_rad  [QW+1];
    logic [QW:0]   w_rem  [QW+1];
    logic [QW-1:0] w_root [QW+1];

    assign w_rad[0]  = r_s3_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar g = 0; g < QW; g++) begin : g_sqrt
        bmg_sqrt_cell #(.RW(RW), .QW(QW)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_rad  (w_rad[g]),
            .i_rem  (w_rem[g]),
            .i_root (w_root[g]),
            .o_rad  (w_rad[g+1]),
            .o_rem  (w_rem[g+1]),
            .o_root (w_root[g+1])
        );
    end

    // ---------------- Angle path: fold, series, quadrant ----------------
    bmg_delay #(.WIDTH(UNIFORM_BITS), .DEPTH(PAD)) u_angle_dly (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   (w_u2),
        .o_q   (w_u2_dly)
    );

    logic [31:0] w_p;
    logic [29:0] w_a;
    logic        w_swap;
    t_q30        r_a0_a;
    t_octant     r_a0_oct;
    logic [61:0] w_th;
    t_q30        r_a1_th;
    t_octant     r_a1_oct;
    logic [61:0] w_t2;
    t_q30        r_a2_th, r_a2_t2;
    t_octant     r_a2_oct;

    assign w_p    = 32'({w_u2_dly, 32'b0} >> UNIFORM_BITS);
    assign w_a    = w_p[29:0];
    assign w_swap = w_a > 30'h2000_0000;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a0_a        <= w_swap ? (Q30_ONE - 31'(w_a)) : 31'(w_a);
            r_a0_oct.quad <= t_quad'(w_p[31:30]);
            r_a0_oct.swap <= w_swap;
        end
    end

    assign w_th = 62'(r_a0_a) * 62'(HALF_PI_Q30);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a1_th  <= w_th[60:30];
            r_a1_oct <= r_a0_oct;
        end
    end

    assign w_t2 = 62'(r_a1_th) * 62'(r_a1_th);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a2_th  <= r_a1_th;
            r_a2_t2  <= w_t2[60:30];
            r_a2_oct <= r_a1_oct;
        end
    end

    t_q30    w_st2 [SERIES_CELLS+1];
    t_q30    w_stc [SERIES_CELLS+1];
    t_q30    w_sts [SERIES_CELLS+1];
    t_trig   w_sc  [SERIES_CELLS+1];
    t_trig   w_ss  [SERIES_CELLS+1];
    t_octant w_so  [SERIES_CELLS+1];

    assign w_st2[0] = r_a2_t2;
    assign w_stc[0] = Q30_ONE;
    assign w_sts[0] = r_a2_th;
    assign w_sc[0]  = '0;
    assign w_ss[0]  = '0;
    assign w_so[0]  = r_a2_oct;

    for (genvar g = 0; g < SERIES_CELLS; g++) begin : g_series
        bmg_series_cell #(
            .COS_DIV (cos_div(g)),
            .SIN_DIV (sin_div(g)),
            .NEGATE  (1'(g % 2))
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_t2  (w_st2[g]),
            .i_tc  (w_stc[g]),
            .i_ts  (w_sts[g]),
            .i_c   (w_sc[g]),
            .i_s   (w_ss[g]),
            .i_oct (w_so[g]),
            .o_t2  (w_st2[g+1]),
            .o_tc  (w_stc[g+1]),
            .o_ts  (w_sts[g+1]),
            .o_c   (w_sc[g+1]),
            .o_s   (w_ss[g+1]),
            .o_oct (w_so[g+1])
        );
    end

    t_trig   r_f1_c, r_f1_s;
    t_octant r_f1_oct;
    t_trig   w_c0, w_s0, n_f2_c, n_f2_s;
    t_trig   r_f2_c, r_f2_s;

    // The last term is even, so it is added.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1_c   <= w_sc[SERIES_CELLS] + t_trig'(w_stc[SERIES_CELLS]);
            r_f1_s   <= w_ss[SERIES_CELLS] + t_trig'(w_sts[SERIES_CELLS]);
            r_f1_oct <= w_so[SERIES_CELLS];
        end
    end

    assign w_c0 = r_f1_oct.swap ? r_f1_s : r_f1_c;
    assign w_s0 = r_f1_oct.swap ? r_f1_c : r_f1_s;

    always_comb begin
        unique case (r_f1_oct.quad)
            QUAD_I: begin
                n_f2_c = w_c0;
                n_f2_s = w_s0;
            end
            QUAD_II: begin
                n_f2_c = -w_s0;
                n_f2_s = w_c0;
            end
            QUAD_III: begin
                n_f2_c = -w_c0;
                n_f2_s = -w_s0;
            end
            QUAD_IV: begin
                n_f2_c = w_s0;
                n_f2_s = -w_c0;
            end
            default: begin
                n_f2_c = w_c0;
                n_f2_s = w_s0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f2_c <= n_f2_c;
            r_f2_s <= n_f2_s;
        end
    end

    // ---------------- Product, rounding and saturation ----------------
    logic [30:0]   w_mag_c, w_mag_s;
    logic [PW-1:0] r_o1_pc, r_o1_ps;
    logic          r_o1_nc, r_o1_ns;
    logic [PW:0]   w_qc, w_qs, w_lc, w_ls;
    logic [SAMPLE_BITS-1:0] n_o2_c, n_o2_s;
    logic [SAMPLE_BITS-1:0] r_o2_c, r_o2_s;

    assign w_mag_c = r_f2_c[31] ? 31'(-r_f2_c) : 31'(r_f2_c);
    assign w_mag_s = r_f2_s[31] ? 31'(-r_f2_s) : 31'(r_f2_s);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o1_pc <= PW'(w_root[QW]) * PW'(w_mag_c);
            r_o1_ps <= PW'(w_root[QW]) * PW'(w_mag_s);
            r_o1_nc <= r_f2_c[31];
            r_o1_ns <= r_f2_s[31];
        end
    end

    // Halves round away from zero because rounding is done on the magnitude.
    assign w_qc = ({1'b0, r_o1_pc} + ROUND) >> SH;
    assign w_qs = ({1'b0, r_o1_ps} + ROUND) >> SH;

    always_comb begin
        if (r_o1_nc) begin
            w_lc   = (w_qc > NEG_LIM) ? NEG_LIM : w_qc;
            n_o2_c = -w_lc[SAMPLE_BITS-1:0];
        end else begin
            w_lc   = (w_qc > POS_LIM) ? POS_LIM : w_qc;
            n_o2_c = w_lc[SAMPLE_BITS-1:0];
        end
        if (r_o1_ns) begin
            w_ls   = (w_qs > NEG_LIM) ? NEG_LIM : w_qs;
            n_o2_s = -w_ls[SAMPLE_BITS-1:0];
        end else begin
            w_ls   = (w_qs > POS_LIM) ? POS_LIM : w_qs;
            n_o2_s = w_ls[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o2_c <= n_o2_c;
            r_o2_s <= n_o2_s;
        end
    end

    // ---------------- Output buffer: cosine, then sine ----------------
    logic r_ov, r_phase;
    logic [SAMPLE_BITS-1:0] r_buf_c, r_buf_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_phase <= 1'b0;
        end else if (r_vld[DEPTH-1] && w_can_load) begin
            r_ov    <= 1'b1;
            r_phase <= 1'b0;
        end else if (r_ov && i_m_axis_tready) begin
            if (r_phase) begin
                r_ov <= 1'b0;
            end else begin
                r_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[DEPTH-1] && w_can_load) begin
            r_buf_c <= r_o2_c;
            r_buf_s <= r_o2_s;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tlast  = r_phase;
    assign o_m_axis_tdata  = OUT_W'(r_phase ? r_buf_s : r_buf_c);

`ifndef SYNTH
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_phase && r_vld[DEPTH-1]) |-> !o_s_axis_tready)
        else $error("input accepted while the pipeline tail is blocked");

    a_cos_then_sin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_phase && i_m_axis_tready) |=> (r_ov && r_phase))
        else $error("sine sample did not follow the cosine sample");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_phase && i_m_axis_tready && !r_vld[DEPTH-1]) |=> !r_ov)
        else $error("output buffer did not empty after the sine transaction");

    a_accept_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted item not marked valid in the first stage");
`endif
endmodule

// ----- src/bmg_delay.sv -----
// Enabled shift line that delays a word by a fixed number of stages.
module bmg_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];
endmodule

// ----- src/bmg_log_cell.sv -----
// One squaring step of the base-2 logarithm: yields one fraction bit.
module bmg_log_cell #(
    parameter int EW = 6
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  bmg_pkg::t_q30 i_f,
    input  logic [29:0]   i_frac,
    input  logic [EW-1:0] i_e,
    output bmg_pkg::t_q30 o_f,
    output logic [29:0]   o_frac,
    output logic [EW-1:0] o_e
);
    import bmg_pkg::*;

    logic [61:0] w_sq;
    logic [31:0] w_g;
    logic        w_bit;
    t_q30        n_f;
    t_q30        r_f;
    logic [29:0] r_frac;
    logic [EW-1:0] r_e;

    assign w_sq  = 62'(i_f) * 62'(i_f);
    assign w_g   = w_sq[61:30];
    assign w_bit = w_g[31];
    // A square at or above two contributes a one and is halved back into range.
    assign n_f   = w_bit ? w_g[31:1] : w_g[30:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f    <= n_f;
            r_frac <= {i_frac[28:0], w_bit};
            r_e    <= i_e;
        end
    end

    assign o_f    = r_f;
    assign o_frac = r_frac;
    assign o_e    = r_e;
endmodule

// ----- src/bmg_sqrt_cell.sv -----
// One restoring square-root step: consumes two radicand bits, yields one root bit.
module bmg_sqrt_cell #(
    parameter int RW = 58,
    parameter int QW = 29
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_rad,
    input  logic [QW:0]   i_rem,
    input  logic [QW-1:0] i_root,
    output logic [RW-1:0] o_rad,
    output logic [QW:0]   o_rem,
    output logic [QW-1:0] o_root
);
    logic [QW+2:0] w_cur;
    logic [QW+2:0] w_trial;
    logic [QW+2:0] w_diff;
    logic          w_ge;
    logic [RW-1:0] r_rad;
    logic [QW:0]   r_rem;
    logic [QW-1:0] r_root;

    assign w_cur   = {i_rem, i_rad[RW-1:RW-2]};
    assign w_trial = {1'b0, i_root, 2'b01};
    assign w_ge    = w_cur >= w_trial;
    assign w_diff  = w_cur - w_trial;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= {i_rad[RW-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[QW:0] : w_cur[QW:0];
            r_root <= {i_root[QW-2:0], w_ge};
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule

// ----- src/bmg_series_cell.sv -----
// One Taylor term for cosine and sine: accumulate, then form the next term.
module bmg_series_cell #(
    parameter int COS_DIV = 2,
    parameter int SIN_DIV = 6,
    parameter bit NEGATE  = 1'b0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  bmg_pkg::t_q30    i_t2,
    input  bmg_pkg::t_q30    i_tc,
    input  bmg_pkg::t_q30    i_ts,
    input  bmg_pkg::t_trig   i_c,
    input  bmg_pkg::t_trig   i_s,
    input  bmg_pkg::t_octant i_oct,
    output bmg_pkg::t_q30    o_t2,
    output bmg_pkg::t_q30    o_tc,
    output bmg_pkg::t_q30    o_ts,
    output bmg_pkg::t_trig   o_c,
    output bmg_pkg::t_trig   o_s,
    output bmg_pkg::t_octant o_oct
);
    import bmg_pkg::*;

    // Division by a constant through a reciprocal that is low by at most one.
    localparam int          COS_K     = 31 + $clog2(COS_DIV);
    localparam int          SIN_K     = 31 + $clog2(SIN_DIV);
    localparam logic [31:0] COS_RECIP = 32'((64'd1 << COS_K) / COS_DIV);
    localparam logic [31:0] SIN_RECIP = 32'((64'd1 << SIN_K) / SIN_DIV);

    logic [61:0] w_pc, w_ps;
    logic [62:0] w_qc, w_qs;
    logic [38:0] w_rc, w_rs;
    t_trig       n_c, n_s;

    t_q30    r_a_xc, r_a_xs, r_a_t2;
    t_trig   r_a_c, r_a_s;
    t_octant r_a_oct;
    t_q30    r_b_xc, r_b_xs, r_b_qc, r_b_qs, r_b_t2;
    t_trig   r_b_c, r_b_s;
    t_octant r_b_oct;
    t_q30    r_tc, r_ts, r_t2;
    t_trig   r_c, r_s;
    t_octant r_oct;

    assign n_c  = NEGATE ? (i_c - t_trig'(i_tc)) : (i_c + t_trig'(i_tc));
    assign n_s  = NEGATE ? (i_s - t_trig'(i_ts)) : (i_s + t_trig'(i_ts));
    assign w_pc = 62'(i_tc) * 62'(i_t2);
    assign w_ps = 62'(i_ts) * 62'(i_t2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_xc  <= w_pc[60:30];
            r_a_xs  <= w_ps[60:30];
            r_a_c   <= n_c;
            r_a_s   <= n_s;
            r_a_t2  <= i_t2;
            r_a_oct <= i_oct;
        end
    end

    assign w_qc = 63'(r_a_xc) * 63'(COS_RECIP);
    assign w_qs = 63'(r_a_xs) * 63'(SIN_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_xc  <= r_a_xc;
            r_b_xs  <= r_a_xs;
            r_b_qc  <= 31'(w_qc >> COS_K);
            r_b_qs  <= 31'(w_qs >> SIN_K);
            r_b_c   <= r_a_c;
            r_b_s   <= r_a_s;
            r_b_t2  <= r_a_t2;
            r_b_oct <= r_a_oct;
        end
    end

    assign w_rc = 39'(r_b_xc) - 39'(r_b_qc) * 39'(COS_DIV);
    assign w_rs = 39'(r_b_xs) - 39'(r_b_qs) * 39'(SIN_DIV);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tc  <= r_b_qc + 31'(w_rc >= 39'(COS_DIV));
            r_ts  <= r_b_qs + 31'(w_rs >= 39'(SIN_DIV));
            r_c   <= r_b_c;
            r_s   <= r_b_s;
            r_t2  <= r_b_t2;
            r_oct <= r_b_oct;
        end
    end

    assign o_tc  = r_tc;
    assign o_ts  = r_ts;
    assign o_c   = r_c;
    assign o_s   = r_s;
    assign o_t2  = r_t2;
    assign o_oct = r_oct;
endmodule
